[src/hha_pkg.sv]
// Shared types, constants and helpers for the handle heap allocator.
// No dependencies.
package hha_pkg;

	localparam int NUM_HANDLES     = 256;
	localparam int HANDLE_W        = 8;
	localparam int NUM_CHUNKS      = 4;
	localparam int CHUNK_W         = 2;
	localparam int CNT_W           = 3;
	localparam int MAX_CHUNK_BYTES = 4096;
	localparam int BYTES_W         = 13;
	localparam int OFFSET_W        = 13;  // internal offset, may reach a full chunk
	localparam int OFFSET_OUT_W    = 12;
	localparam int SIZE_W          = 16;
	localparam int RSIZE_W         = 17;
	localparam int SCAN_W          = HANDLE_W + 1;
	localparam int KEY_W           = CHUNK_W + OFFSET_W + HANDLE_W;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RESIZE  = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_HANDLE = 2'd1;
	localparam logic [1:0] ST_NO_SPACE  = 2'd2;

	localparam logic [1:0] REG_CHUNK_COUNT = 2'd0;
	localparam logic [1:0] REG_CHUNK_BYTES = 2'd1;
	localparam logic [1:0] REG_LAST_BYTES  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_COMMIT,
		S_REREAD,
		S_REPORT,
		S_C_INIT,
		S_C_SCAN,
		S_C_PICK,
		S_C_PLACE,
		S_C_COPY
	} state_t;

	typedef struct packed {
		logic [CHUNK_W-1:0]  chunk;
		logic [OFFSET_W-1:0] offset;
	} place_t;

	typedef struct packed {
		place_t              place;
		logic [SIZE_W-1:0]   size;
	} entry_t;

	typedef struct packed {
		logic               clear;
		logic               set;
		logic               add;
		logic [CHUNK_W-1:0] idx;
		logic [BYTES_W-1:0] val;
	} fill_cmd_t;

	function automatic logic [RSIZE_W-1:0] round4(input logic [SIZE_W-1:0] s);
		logic [RSIZE_W-1:0] t;
		t = {1'b0, s} + RSIZE_W'(3);
		return {t[RSIZE_W-1:2], 2'b00};
	endfunction

	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0) r = CNT_W'(1);
		else if (c > CNT_W'(NUM_CHUNKS)) r = CNT_W'(NUM_CHUNKS);
		return r;
	endfunction

	function automatic logic [BYTES_W-1:0] sat_cap(input logic [BYTES_W-1:0] v);
		logic [BYTES_W-1:0] r;
		r = v;
		if (v > BYTES_W'(MAX_CHUNK_BYTES)) r = BYTES_W'(MAX_CHUNK_BYTES);
		return r;
	endfunction

endpackage

[src/hha_entry_ram.sv]
// Handle table RAM: place and size per handle, registered read.
// Depends on hha_pkg.
module hha_entry_ram
	import hha_pkg::*;
(
	input  logic                clk,
	input  logic                rd_en,
	input  logic [HANDLE_W-1:0] raddr,
	output entry_t              rdata,
	input  logic                we_place,
	input  logic                we_size,
	input  logic [HANDLE_W-1:0] waddr,
	input  entry_t              wdata
);

	place_t            place_mem [NUM_HANDLES];
	logic [SIZE_W-1:0] size_mem  [NUM_HANDLES];

	always_ff @(posedge clk) begin
		if (we_place) place_mem[waddr] <= wdata.place;
		if (we_size) size_mem[waddr] <= wdata.size;
		if (rd_en) begin
			rdata.place <= place_mem[raddr];
			rdata.size  <= size_mem[raddr];
		end
	end

endmodule

[src/hha_shadow_ram.sv]
// Scratch RAM holding new places while the heap is repacked.
// Depends on hha_pkg.
module hha_shadow_ram
	import hha_pkg::*;
(
	input  logic                clk,
	input  logic                rd_en,
	input  logic [HANDLE_W-1:0] raddr,
	output place_t              rdata,
	input  logic                we,
	input  logic [HANDLE_W-1:0] waddr,
	input  place_t              wdata
);

	place_t mem [NUM_HANDLES];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (rd_en) rdata <= mem[raddr];
	end

endmodule

[src/hha_chunk_unit.sv]
// Chunk fill registers, capacities and first-fit chunk search.
// Depends on hha_pkg.
module hha_chunk_unit
	import hha_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    cfg_count,
	input  logic [BYTES_W-1:0]  cfg_bytes,
	input  logic [BYTES_W-1:0]  cfg_last,
	input  logic [RSIZE_W-1:0]  req_size,
	input  fill_cmd_t           cmd,
	input  logic [CNT_W-1:0]    cap_sel,
	output logic [CNT_W-1:0]    cnt,
	output logic                hit,
	output logic [CHUNK_W-1:0]  hit_chunk,
	output logic [OFFSET_W-1:0] hit_offset,
	output logic [BYTES_W-1:0]  cap_val
);

	logic [BYTES_W-1:0] fill_q [NUM_CHUNKS];
	logic [BYTES_W-1:0] cap    [NUM_CHUNKS];

	assign cnt = sat_count(cfg_count);

	always_comb begin
		hit       = 1'b0;
		hit_chunk = '0;
		for (int c = 0; c < NUM_CHUNKS; c++) begin
			cap[c] = (CNT_W'(c + 1) == cnt) ? sat_cap(cfg_last) : sat_cap(cfg_bytes);
		end
		// lowest chunk with room wins
		for (int c = NUM_CHUNKS - 1; c >= 0; c--) begin
			if ((CNT_W'(c) < cnt) && (fill_q[c] <= cap[c]) &&
			    ({{(RSIZE_W-BYTES_W){1'b0}}, cap[c] - fill_q[c]} >= req_size)) begin
				hit       = 1'b1;
				hit_chunk = CHUNK_W'(c);
			end
		end
		hit_offset = fill_q[hit_chunk];
		cap_val    = cap[cap_sel[CHUNK_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHUNKS; c++) fill_q[c] <= '0;
		end else if (cmd.clear) begin
			for (int c = 0; c < NUM_CHUNKS; c++) fill_q[c] <= '0;
		end else if (cmd.set) begin
			fill_q[cmd.idx] <= cmd.val;
		end else if (cmd.add) begin
			fill_q[cmd.idx] <= fill_q[cmd.idx] + cmd.val;
		end
	end

endmodule

[src/compacting_handle_heap_allocator.sv]
// Top level of the handle heap allocator: request sequencer and compaction.
// Depends on hha_pkg, hha_entry_ram, hha_shadow_ram, hha_chunk_unit.
//
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------
// request   | start / busy         | operation, handle, byte_count
// result    | done (1-cycle strobe)| status, handle_out, chunk_out, offset_out
// config    | cfg_we               | cfg_index, cfg_wdata
//
// A request without repacking passes from acceptance through decode on the
// handle table read, chunk search and table write before its result is taken.
// When no chunk has room the heap is repacked: each live block costs one walk
// of the 256-entry handle table through its single read port, and a final copy
// moves the new places from the shadow RAM into the handle table.
// busy is high from acceptance until the result strobe; done is never held off.
// Reset clears all handles to free and all chunk fills to zero, immediately.

module compacting_handle_heap_allocator
	import hha_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              operation,
	input  logic [HANDLE_W-1:0]     handle,
	input  logic [SIZE_W-1:0]       byte_count,
	output logic                    done,
	output logic [1:0]              status,
	output logic [HANDLE_W-1:0]     handle_out,
	output logic [CHUNK_W-1:0]      chunk_out,
	output logic [OFFSET_OUT_W-1:0] offset_out,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [BYTES_W-1:0]      cfg_wdata
);

	state_t state_q, state_d;

	// configuration
	logic [CNT_W-1:0]   chunk_count_q;
	logic [BYTES_W-1:0] chunk_bytes_q, last_bytes_q;

	// request context
	op_t                 op_q;
	logic [HANDLE_W-1:0] h_q, f_q;
	logic [SIZE_W-1:0]   size_q;
	logic [RSIZE_W-1:0]  sz_q;
	logic                attempt_q;
	logic [CHUNK_W-1:0]  hit_c_q;
	logic [OFFSET_W-1:0] hit_o_q;

	// live bits and lowest free handle
	logic [NUM_HANDLES-1:0] live_q;
	logic [HANDLE_W-1:0]    free_idx_q, free_idx_d;
	logic                   free_none_q, free_none_d;

	// repacking
	logic [SCAN_W-1:0]   scan_cnt_q, copy_cnt_q;
	logic                scan_v_s1, copy_v_s1;
	logic [HANDLE_W-1:0] scan_idx_s1, copy_idx_s1;
	logic                have_prev_q, best_found_q;
	logic [KEY_W-1:0]    prev_key_q, best_key_q, key_now;
	logic [SIZE_W-1:0]   best_size_q;
	logic [CNT_W-1:0]    c_q;
	logic [OFFSET_W-1:0] pos_q;
	logic [RSIZE_W-1:0]  csz_q;
	logic                cand;
	logic [HANDLE_W-1:0] best_h;

	// memories and chunk unit
	logic                ent_rd_en, ent_we_place, ent_we_size;
	logic [HANDLE_W-1:0] ent_raddr, ent_waddr;
	entry_t              ent_rdata, ent_wdata;
	logic                sh_rd_en, sh_we;
	logic [HANDLE_W-1:0] sh_raddr, sh_waddr;
	place_t              sh_rdata, sh_wdata;
	fill_cmd_t           fcmd;
	logic [CNT_W-1:0]    cnt;
	logic                hit;
	logic [CHUNK_W-1:0]  hit_chunk;
	logic [OFFSET_W-1:0] hit_offset;
	logic [BYTES_W-1:0]  cap_val;

	// result
	logic                rsp_fire;
	logic [1:0]          rsp_status;
	logic [HANDLE_W-1:0] rsp_handle;
	logic [CHUNK_W-1:0]  rsp_chunk;
	logic [OFFSET_W-1:0] rsp_offset;
	logic                done_q;
	logic [1:0]          status_q;
	logic [HANDLE_W-1:0] handle_out_q;
	logic [CHUNK_W-1:0]  chunk_out_q;
	logic [OFFSET_OUT_W-1:0] offset_out_q;

	hha_entry_ram u_entry (
		.clk      (clk),
		.rd_en    (ent_rd_en),
		.raddr    (ent_raddr),
		.rdata    (ent_rdata),
		.we_place (ent_we_place),
		.we_size  (ent_we_size),
		.waddr    (ent_waddr),
		.wdata    (ent_wdata)
	);

	hha_shadow_ram u_shadow (
		.clk   (clk),
		.rd_en (sh_rd_en),
		.raddr (sh_raddr),
		.rdata (sh_rdata),
		.we    (sh_we),
		.waddr (sh_waddr),
		.wdata (sh_wdata)
	);

	hha_chunk_unit u_chunks (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_count  (chunk_count_q),
		.cfg_bytes  (chunk_bytes_q),
		.cfg_last   (last_bytes_q),
		.req_size   (sz_q),
		.cmd        (fcmd),
		.cap_sel    (c_q),
		.cnt        (cnt),
		.hit        (hit),
		.hit_chunk  (hit_chunk),
		.hit_offset (hit_offset),
		.cap_val    (cap_val)
	);

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign handle_out = handle_out_q;
	assign chunk_out  = chunk_out_q;
	assign offset_out = offset_out_q;

	assign best_h  = best_key_q[HANDLE_W-1:0];
	assign key_now = {ent_rdata.place.chunk, ent_rdata.place.offset, scan_idx_s1};
	// next block in address order: above the last one placed or dropped, below the best so far
	assign cand = scan_v_s1 && live_q[scan_idx_s1] &&
	              (!have_prev_q || (key_now > prev_key_q)) &&
	              (!best_found_q || (key_now < best_key_q));

	// lowest free handle, registered every cycle
	always_comb begin
		free_idx_d  = '0;
		free_none_d = 1'b1;
		for (int i = NUM_HANDLES - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_none_d = 1'b0;
				free_idx_d  = HANDLE_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		ent_rd_en    = 1'b0;
		ent_raddr    = h_q;
		ent_we_place = 1'b0;
		ent_we_size  = 1'b0;
		ent_waddr    = h_q;
		ent_wdata    = '0;
		sh_rd_en     = 1'b0;
		sh_raddr     = copy_cnt_q[HANDLE_W-1:0];
		sh_we        = 1'b0;
		sh_waddr     = best_h;
		sh_wdata     = '{chunk: c_q[CHUNK_W-1:0], offset: pos_q};
		fcmd         = '0;
		rsp_fire     = 1'b0;
		rsp_status   = ST_OK;
		rsp_handle   = h_q;
		rsp_chunk    = '0;
		rsp_offset   = '0;
		unique case (state_q)
			S_IDLE: begin
				ent_rd_en = 1'b1;
				ent_raddr = handle;
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (op_q)
					OP_ALLOC: begin
						if (free_none_q) begin
							rsp_fire   = 1'b1;
							rsp_status = ST_NO_HANDLE;
							rsp_handle = '0;
							state_d    = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_RESIZE: begin
						if (!live_q[h_q]) begin
							rsp_fire   = 1'b1;
							rsp_status = ST_NO_HANDLE;
							state_d    = S_IDLE;
						end else if (size_q > ent_rdata.size) begin
							state_d = S_SCAN;
						end else begin
							// shrink in place
							ent_we_size    = 1'b1;
							ent_wdata.size = size_q;
							rsp_fire       = 1'b1;
							rsp_chunk      = ent_rdata.place.chunk;
							rsp_offset     = ent_rdata.place.offset;
							state_d        = S_IDLE;
						end
					end
					default: begin
						rsp_fire = 1'b1;
						state_d  = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				if (hit) begin
					fcmd.add = 1'b1;
					fcmd.idx = hit_chunk;
					fcmd.val = sz_q[BYTES_W-1:0];
					state_d  = S_COMMIT;
				end else if (!attempt_q) begin
					state_d = S_C_INIT;
				end else if (op_q == OP_ALLOC) begin
					rsp_fire   = 1'b1;
					rsp_status = ST_NO_SPACE;
					rsp_handle = '0;
					state_d    = S_IDLE;
				end else if (live_q[h_q]) begin
					state_d = S_REREAD;
				end else begin
					rsp_fire   = 1'b1;
					rsp_status = ST_NO_SPACE;
					state_d    = S_IDLE;
				end
			end
			S_COMMIT: begin
				rsp_fire = 1'b1;
				state_d  = S_IDLE;
				if (op_q == OP_ALLOC) begin
					ent_we_place    = 1'b1;
					ent_we_size     = 1'b1;
					ent_waddr       = f_q;
					ent_wdata.place = '{chunk: hit_c_q, offset: hit_o_q};
					ent_wdata.size  = size_q;
					rsp_handle      = f_q;
					rsp_chunk       = hit_c_q;
					rsp_offset      = hit_o_q;
				end else if (live_q[h_q]) begin
					ent_we_place    = 1'b1;
					ent_we_size     = 1'b1;
					ent_wdata.place = '{chunk: hit_c_q, offset: hit_o_q};
					ent_wdata.size  = size_q;
					rsp_chunk       = hit_c_q;
					rsp_offset      = hit_o_q;
				end else begin
					rsp_status = ST_NO_SPACE;
				end
			end
			S_REREAD: begin
				ent_rd_en = 1'b1;
				state_d   = S_REPORT;
			end
			S_REPORT: begin
				rsp_fire   = 1'b1;
				rsp_status = ST_NO_SPACE;
				rsp_chunk  = ent_rdata.place.chunk;
				rsp_offset = ent_rdata.place.offset;
				state_d    = S_IDLE;
			end
			S_C_INIT: begin
				fcmd.clear = 1'b1;
				state_d    = S_C_SCAN;
			end
			S_C_SCAN: begin
				ent_rd_en = !scan_cnt_q[SCAN_W-1];
				ent_raddr = scan_cnt_q[HANDLE_W-1:0];
				if (scan_cnt_q[SCAN_W-1] && !scan_v_s1) state_d = S_C_PICK;
			end
			S_C_PICK: begin
				if (!best_found_q) begin
					if (c_q < cnt) begin
						fcmd.set = 1'b1;
						fcmd.idx = c_q[CHUNK_W-1:0];
						fcmd.val = pos_q;
					end
					state_d = S_C_COPY;
				end else begin
					state_d = S_C_PLACE;
				end
			end
			S_C_PLACE: begin
				if (c_q >= cnt) begin
					state_d = S_C_SCAN;
				end else if (csz_q > {{(RSIZE_W-BYTES_W){1'b0}}, cap_val - pos_q}) begin
					fcmd.set = 1'b1;
					fcmd.idx = c_q[CHUNK_W-1:0];
					fcmd.val = pos_q;
				end else begin
					sh_we   = 1'b1;
					state_d = S_C_SCAN;
				end
			end
			S_C_COPY: begin
				sh_rd_en        = !copy_cnt_q[SCAN_W-1];
				ent_we_place    = copy_v_s1 && live_q[copy_idx_s1];
				ent_waddr       = copy_idx_s1;
				ent_wdata.place = sh_rdata;
				if (copy_cnt_q[SCAN_W-1] && !copy_v_s1) state_d = S_SCAN;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q <= CNT_W'(NUM_CHUNKS);
			chunk_bytes_q <= BYTES_W'(MAX_CHUNK_BYTES);
			last_bytes_q  <= BYTES_W'(MAX_CHUNK_BYTES);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHUNK_COUNT: chunk_count_q <= cfg_wdata[CNT_W-1:0];
				REG_CHUNK_BYTES: chunk_bytes_q <= cfg_wdata;
				REG_LAST_BYTES:  last_bytes_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// datapath and live bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q       <= '0;
			free_idx_q   <= '0;
			free_none_q  <= 1'b0;
			op_q         <= OP_ALLOC;
			h_q          <= '0;
			f_q          <= '0;
			size_q       <= '0;
			sz_q         <= '0;
			attempt_q    <= 1'b0;
			hit_c_q      <= '0;
			hit_o_q      <= '0;
			scan_cnt_q   <= '0;
			copy_cnt_q   <= '0;
			scan_v_s1    <= 1'b0;
			copy_v_s1    <= 1'b0;
			scan_idx_s1  <= '0;
			copy_idx_s1  <= '0;
			have_prev_q  <= 1'b0;
			best_found_q <= 1'b0;
			prev_key_q   <= '0;
			best_key_q   <= '0;
			best_size_q  <= '0;
			c_q          <= '0;
			pos_q        <= '0;
			csz_q        <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			handle_out_q <= '0;
			chunk_out_q  <= '0;
			offset_out_q <= '0;
		end else begin
			free_idx_q  <= free_idx_d;
			free_none_q <= free_none_d;
			scan_v_s1   <= (state_q == S_C_SCAN) && !scan_cnt_q[SCAN_W-1];
			scan_idx_s1 <= scan_cnt_q[HANDLE_W-1:0];
			copy_v_s1   <= (state_q == S_C_COPY) && !copy_cnt_q[SCAN_W-1];
			copy_idx_s1 <= copy_cnt_q[HANDLE_W-1:0];

			done_q <= rsp_fire;
			if (rsp_fire) begin
				status_q     <= rsp_status;
				handle_out_q <= rsp_handle;
				chunk_out_q  <= rsp_chunk;
				offset_out_q <= rsp_offset[OFFSET_OUT_W-1:0];
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= op_t'(operation);
						h_q       <= handle;
						size_q    <= byte_count;
						sz_q      <= round4(byte_count);
						attempt_q <= 1'b0;
					end
				end
				S_DECODE: begin
					f_q <= free_idx_q;
					if (op_q == OP_RELEASE) live_q[h_q] <= 1'b0;
				end
				S_SCAN: begin
					hit_c_q <= hit_chunk;
					hit_o_q <= hit_offset;
				end
				S_COMMIT: begin
					if (op_q == OP_ALLOC) live_q[f_q] <= 1'b1;
				end
				S_C_INIT: begin
					attempt_q    <= 1'b1;
					c_q          <= '0;
					pos_q        <= '0;
					have_prev_q  <= 1'b0;
					best_found_q <= 1'b0;
					scan_cnt_q   <= '0;
				end
				S_C_SCAN: begin
					if (!scan_cnt_q[SCAN_W-1]) scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
					if (cand) begin
						best_found_q <= 1'b1;
						best_key_q   <= key_now;
						best_size_q  <= ent_rdata.size;
					end
				end
				S_C_PICK: begin
					csz_q      <= round4(best_size_q);
					copy_cnt_q <= '0;
				end
				S_C_PLACE: begin
					if (c_q >= cnt) begin
						// fits nowhere: the block is dropped
						live_q[best_h] <= 1'b0;
						prev_key_q     <= best_key_q;
						have_prev_q    <= 1'b1;
						best_found_q   <= 1'b0;
						scan_cnt_q     <= '0;
					end else if (csz_q > {{(RSIZE_W-BYTES_W){1'b0}}, cap_val - pos_q}) begin
						c_q   <= c_q + CNT_W'(1);
						pos_q <= '0;
					end else begin
						pos_q        <= pos_q + csz_q[OFFSET_W-1:0];
						prev_key_q   <= best_key_q;
						have_prev_q  <= 1'b1;
						best_found_q <= 1'b0;
						scan_cnt_q   <= '0;
					end
				end
				S_C_COPY: begin
					if (!copy_cnt_q[SCAN_W-1]) copy_cnt_q <= copy_cnt_q + SCAN_W'(1);
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a result only appears once the block has let go of busy
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// an accepted request always makes the block busy from the next cycle on
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// repacking never fills a chunk beyond its capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_C_PLACE) && (c_q < cnt)) |-> ({1'b0, pos_q} <= {1'b0, cap_val}))
		else $error("repack position beyond chunk capacity");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for compacting_handle_heap_allocator: heap requests go in
// through start/busy, and results are checked against a behavioural heap model.
// Depends on hha_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_top;
	import hha_pkg::*;

	localparam int LIVE_CAP = 32;      // keeps repack walks short

	typedef struct {
		op_t         op;
		logic [7:0]  hnd;
		logic [15:0] bytes;
		bit          pick_live;        // swap in a live handle when issued
	} heap_req_t;

	typedef struct {
		logic [1:0]  st;
		logic [7:0]  hnd;
		logic [1:0]  chunk;
		logic [11:0] offset;
	} heap_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] operation = '0;
	logic [HANDLE_W-1:0] handle = '0;
	logic [SIZE_W-1:0] byte_count = '0;
	logic done;
	logic [1:0] status;
	logic [HANDLE_W-1:0] handle_out;
	logic [CHUNK_W-1:0] chunk_out;
	logic [OFFSET_OUT_W-1:0] offset_out;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [BYTES_W-1:0] cfg_wdata = '0;

	compacting_handle_heap_allocator DUT (.*);

	always #1 clk = ~clk;

	// heap model state
	logic [2:0]  m_count;
	logic [12:0] m_bytes, m_last;
	bit          m_live [NUM_HANDLES];
	int          m_chunk [NUM_HANDLES];
	int          m_off [NUM_HANDLES];
	int          m_size [NUM_HANDLES];
	int          m_fill [NUM_CHUNKS];

	heap_req_t req_queue[$];
	heap_res_t pending_results[$];
	int errors = 0, n_issued = 0, n_checked = 0, n_repacks = 0, n_fails = 0;
	int gap_left = 0, burst_left = 1;
	bit accepted;
	bit cap_live = 1'b1;               // turn allocates into releases at LIVE_CAP
	heap_req_t cur;

	function automatic int used_chunks();
		int n;
		n = m_count;
		if (n < 1) n = 1;
		if (n > NUM_CHUNKS) n = NUM_CHUNKS;
		return n;
	endfunction

	function automatic int chunk_room(int c);
		int v;
		v = (c + 1 == used_chunks()) ? m_last : m_bytes;
		if (v > MAX_CHUNK_BYTES) v = MAX_CHUNK_BYTES;
		return v;
	endfunction

	function automatic int up4(int s);
		return (s + 3) & ~3;
	endfunction

	function automatic longint place_key(int h);
		return (longint'(m_chunk[h]) << 32) | longint'(m_off[h]);
	endfunction

	function automatic int live_count();
		int n;
		n = 0;
		foreach (m_live[i]) if (m_live[i]) n++;
		return n;
	endfunction

	// repack live blocks in address order; blocks that no longer fit are dropped
	task automatic repack_heap();
		int order[$];
		int j, c, pos, cnt, sz, h;
		c = 0;
		pos = 0;
		cnt = used_chunks();
		n_repacks++;
		for (int i = 0; i < NUM_HANDLES; i++) begin
			if (m_live[i]) begin
				j = order.size();
				while (j > 0 && place_key(order[j-1]) > place_key(i)) j--;
				order.insert(j, i);
			end
		end
		foreach (m_fill[i]) m_fill[i] = 0;
		foreach (order[i]) begin
			h = order[i];
			sz = up4(m_size[h]);
			while (c < cnt && sz > chunk_room(c) - pos) begin
				m_fill[c] = pos;
				c++;
				pos = 0;
			end
			if (c >= cnt) begin
				m_live[h] = 1'b0;
				continue;
			end
			m_chunk[h] = c;
			m_off[h] = pos;
			pos += sz;
		end
		if (c < cnt) m_fill[c] = pos;
	endtask

	function automatic bit first_fit(int sz, output int oc, output int oo);
		int room;
		oc = 0;
		oo = 0;
		for (int c = 0; c < used_chunks(); c++) begin
			room = chunk_room(c);
			if (m_fill[c] <= room && room - m_fill[c] >= sz) begin
				oc = c;
				oo = m_fill[c];
				m_fill[c] += sz;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic place_block(int size, output bit ok, output int oc, output int oo);
		ok = first_fit(up4(size), oc, oo);
		if (!ok) begin
			repack_heap();
			ok = first_fit(up4(size), oc, oo);
		end
	endtask

	// apply one accepted request to the model and queue the expected result
	task automatic heap_apply(logic [1:0] op, logic [7:0] h, logic [15:0] size);
		heap_res_t r;
		int f, c, o;
		bit ok;
		r.st = ST_OK;
		r.hnd = h;
		r.chunk = '0;
		r.offset = '0;
		case (op)
			OP_ALLOC: begin
				f = 0;
				while (f < NUM_HANDLES && m_live[f]) f++;
				r.hnd = '0;
				if (f >= NUM_HANDLES) r.st = ST_NO_HANDLE;
				else begin
					place_block(size, ok, c, o);
					if (!ok) r.st = ST_NO_SPACE;
					else begin
						m_live[f] = 1'b1;
						m_chunk[f] = c;
						m_off[f] = o;
						m_size[f] = size;
						r.hnd = f[7:0];
						r.chunk = c[1:0];
						r.offset = o[11:0];
					end
				end
			end
			OP_RESIZE: begin
				if (!m_live[h]) r.st = ST_NO_HANDLE;
				else begin
					if (size > m_size[h]) begin
						place_block(size, ok, c, o);
						if (ok && m_live[h]) begin
							m_chunk[h] = c;
							m_off[h] = o;
							m_size[h] = size;
						end else r.st = ST_NO_SPACE;
					end else m_size[h] = size;
					// a repack may have dropped the block itself
					if (m_live[h]) begin
						r.chunk = m_chunk[h][1:0];
						r.offset = m_off[h][11:0];
					end else r.st = ST_NO_SPACE;
				end
			end
			OP_RELEASE: m_live[h] = 1'b0;
			default: ;
		endcase
		if (r.st != ST_OK) n_fails++;
		pending_results.push_back(r);
	endtask

	task automatic flag_mismatch(string what);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic logic [7:0] some_live();
		int picks[$];
		foreach (m_live[i]) if (m_live[i]) picks.push_back(i);
		if (picks.size() == 0) return 8'($urandom_range(0, 255));
		return 8'(picks[$urandom_range(0, picks.size() - 1)]);
	endfunction

	// sender: bursts with random gaps; the model is updated at each acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			accepted = start && !busy;
			if (accepted) heap_apply(operation, handle, byte_count);
			if (start && !accepted) begin
				// request still waiting: hold it
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (req_queue.size() > 0) begin
				cur = req_queue.pop_front();
				if (cur.op == OP_ALLOC && cap_live && live_count() >= LIVE_CAP) begin
					cur.op = OP_RELEASE;
					cur.pick_live = 1'b1;
				end
				if (cur.pick_live) cur.hnd = some_live();
				operation <= cur.op;
				handle <= cur.hnd;
				byte_count <= cur.bytes;
				start <= 1'b1;
				n_issued++;
				if (--burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end
			end else start <= 1'b0;
		end
	end

	// result checker: done is a one-cycle strobe that cannot be held off
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) flag_mismatch("result with nothing expected");
			else begin
				heap_res_t e;
				e = pending_results.pop_front();
				n_checked++;
				if (status !== e.st)
					flag_mismatch($sformatf("status %0d want %0d", status, e.st));
				if (handle_out !== e.hnd)
					flag_mismatch($sformatf("handle_out %0d want %0d", handle_out, e.hnd));
				if (chunk_out !== e.chunk)
					flag_mismatch($sformatf("chunk_out %0d want %0d", chunk_out, e.chunk));
				if (offset_out !== e.offset)
					flag_mismatch($sformatf("offset_out %0d want %0d", offset_out, e.offset));
			end
		end
	end

	task automatic queue_req(op_t op, int h, int sz, bit pick = 1'b0);
		heap_req_t q;
		q.op = op;
		q.hnd = h[7:0];
		q.bytes = sz[15:0];
		q.pick_live = pick;
		req_queue.push_back(q);
	endtask

	// the test sequence waits here until every request is sent and every result is back
	task automatic drain();
		do @(negedge clk);
		while (req_queue.size() != 0 || start || pending_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[12:0];
		case (idx)
			REG_CHUNK_COUNT: m_count = val[2:0];
			REG_CHUNK_BYTES: m_bytes = val[12:0];
			default: m_last = val[12:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_heap(int cnt, int cb, int lb);
		write_reg(REG_CHUNK_COUNT, cnt);
		write_reg(REG_CHUNK_BYTES, cb);
		write_reg(REG_LAST_BYTES, lb);
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0: return 0;
			7: return $urandom_range(257, 2048);
			8: return $urandom_range(4093, 4096);
			9: return $urandom_range(0, 65535);
			default: return $urandom_range(1, 256);
		endcase
	endfunction

	initial begin
		int k;
		m_count = 3'd4;
		m_bytes = 13'd4096;
		m_last = 13'd4096;
		foreach (m_live[i]) begin
			m_live[i] = 1'b0;
			m_chunk[i] = 0;
			m_off[i] = 0;
			m_size[i] = 0;
		end
		foreach (m_fill[i]) m_fill[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset sizes, rounding, shrink/grow, dead handles, op 3
		queue_req(OP_ALLOC, 255, 0);
		queue_req(OP_ALLOC, 0, 1);
		queue_req(OP_ALLOC, 0, 3);
		queue_req(OP_ALLOC, 0, 4);
		queue_req(OP_ALLOC, 0, 4096);
		queue_req(OP_ALLOC, 0, 65535);       // fits nowhere, repack then fail
		queue_req(OP_RESIZE, 1, 2);          // size 1 to 2 is a grow, so it moves
		queue_req(OP_RESIZE, 1, 100);        // grow moves
		queue_req(OP_RESIZE, 200, 8);        // handle not live
		queue_req(OP_RESIZE, 2, 65535);      // grow fails
		queue_req(OP_RELEASE, 2, 0);
		queue_req(OP_RELEASE, 2, 0);         // second release: no change
		queue_req(OP_NOP, 255, 65535);
		queue_req(OP_ALLOC, 0, 8);           // reuses lowest free handle
		queue_req(OP_RESIZE, 0, 0);
		drain();
		// shrink the heap so existing fills exceed capacity and blocks drop out
		set_heap(2, 8, 8);
		queue_req(OP_ALLOC, 0, 12);
		queue_req(OP_ALLOC, 0, 8);
		queue_req(OP_ALLOC, 0, 0);
		queue_req(OP_RESIZE, 0, 16, 1'b1);
		drain();
		set_heap(0, 0, 0);                   // count saturates up, zero room
		queue_req(OP_ALLOC, 0, 0);
		queue_req(OP_ALLOC, 0, 4);
		queue_req(OP_RELEASE, 0, 0, 1'b1);
		drain();
		set_heap(7, 8191, 8191);             // both saturate
		queue_req(OP_ALLOC, 0, 4096);
		queue_req(OP_ALLOC, 0, 16384);

		// random phases, each on its own heap shape
		for (int ph = 0; ph < 9; ph++) begin
			drain();
			case (ph)
				0: set_heap(4, 4096, 4096);
				1: set_heap(1, 5, 64);
				2: set_heap(2, 256, 128);
				3: set_heap(4, 512, 100);
				4: set_heap(3, 0, 300);
				5: set_heap(7, 8191, 1);
				6: set_heap(5, 1024, 8191);
				default: set_heap($urandom_range(0, 7), $urandom_range(0, 8191),
						$urandom_range(0, 8191));
			endcase
			for (int i = 0; i < 40; i++) begin
				k = $urandom_range(0, 99);
				if (k < 40) queue_req(OP_ALLOC, $urandom_range(0, 255), pick_size());
				else if (k < 68) queue_req(OP_RESIZE, 0, pick_size(), 1'b1);
				else if (k < 92) queue_req(OP_RELEASE, 0, 0, 1'b1);
				else if (k < 97)
					queue_req(op_t'($urandom_range(1, 2)), $urandom_range(0, 255),
						$urandom_range(0, 65535));
				else queue_req(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 65535));
			end
		end

		// exhaust all handles with empty blocks, then free a few again
		drain();
		cap_live = 1'b0;
		set_heap(1, 0, 0);
		for (int i = 0; i <= NUM_HANDLES; i++) queue_req(OP_ALLOC, 0, 0);
		queue_req(OP_RESIZE, 255, 0);
		for (int i = 0; i < 8; i++) queue_req(OP_RELEASE, i, 0);
		drain();
		repeat (50) @(negedge clk);

		$display("tb_top: %0d requests, %0d results checked, %0d refused", n_issued,
			n_checked, n_fails);
		$display("tb_top: %0d repacks over several heap shapes", n_repacks);
		if (errors == 0) $display("tb_top: done, clean");
		else $display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

[compacting_handle_heap_allocator.f]
src/hha_pkg.sv
src/hha_entry_ram.sv
src/hha_shadow_ram.sv
src/hha_chunk_unit.sv
src/compacting_handle_heap_allocator.sv
tb/sv/tb_top.sv
